@@ design/qat_pkg.sv @@
// ----------------------------------------------------------------------------
// qat_pkg
// Shared types and character constants for the quoted argument tokenizer.
// ----------------------------------------------------------------------------
package qat_pkg;

    localparam logic [7:0] CH_DQ  = 8'h22;
    localparam logic [7:0] CH_SQ  = 8'h27;
    localparam logic [7:0] CH_BS  = 8'h5C;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_SP  = 8'h20;

    localparam int unsigned REG_KEEP_QUOTES = 0;

    // Scan mode of the tokenizer, one-hot coded.
    typedef enum logic [3:0] {
        MODE_IDLE  = 4'b0001,
        MODE_PLAIN = 4'b0010,
        MODE_DQ    = 4'b0100,
        MODE_SQ    = 4'b1000
    } t_mode;

    // One result item as it leaves the block.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       token_end;
        logic       line_end;
    } t_result;

    // Handoff from the scanner to the result register.
    typedef struct packed {
        logic    has_result;
        t_result result;
    } t_step_out;

endpackage

@@ design/quoted_argument_tokenizer.sv @@
// ----------------------------------------------------------------------------
// quoted_argument_tokenizer
// Streaming command-line argument tokenizer, one byte per transfer.
// ----------------------------------------------------------------------------
// The block takes one byte per cycle unless the result register is stalled
// and full, and gives zero or one result per byte; each byte passes an input
// register, the classifier, and a result register. A byte that causes no
// result (a blank between tokens, or an opening quote while keep_quotes is
// clear) simply drops out of the pipe. Each result carries a token byte
// (byte_valid), a token_end flag that closes the current token, and a
// line_end flag on the result for the string terminator. Quoted tokens end
// only at their matching quote or the terminator, a backslash before a blank
// or quote makes it literal while both bytes are kept, and keep_quotes
// (register 0 on the APB port, byte address 0) selects whether enclosing
// quotes are passed on. Write keep_quotes only while no transfer is in flight.
// ----------------------------------------------------------------------------
module quoted_argument_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // APB-style configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // Input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_char_in,
    input  logic        i_end_of_string,

    // Output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_token_end,
    output logic        o_line_end
);

    // Configuration register. Registers are word spaced, so paddr[2] picks
    // the register and the low bits are the byte offset within it.
    logic r_keep_quotes;
    logic cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[2:2] == 1'(qat_pkg::REG_KEEP_QUOTES));
    assign prdata  = cfg_hit ? {31'd0, r_keep_quotes} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_quotes <= 1'b0;
        end else if (psel && penable && pwrite && pready && cfg_hit) begin
            r_keep_quotes <= pwdata[0];
        end
    end

    // Input register. It is refilled whenever its byte moves on to the
    // classifier, so the pipe takes a byte in every cycle unless the
    // result register is stalled and full.
    logic       r_in_valid;
    logic [7:0] r_char;
    logic       r_eos;
    logic       out_free;
    logic       advance;
    logic       in_accept;

    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_char <= i_char_in;
            r_eos  <= i_end_of_string;
        end
    end

    // Classifier with the scan state; its state moves only when the byte
    // in the input register is consumed.
    qat_pkg::t_step_out step;

    qat_scanner u_scanner (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (advance),
        .i_char        (r_char),
        .i_eos         (r_eos),
        .i_keep_quotes (r_keep_quotes),
        .o_step        (step)
    );

    // Result register, drained by the output handshake.
    qat_pkg::t_result result;

    qat_result_reg u_result_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_step      (step),
        .i_out_stall (i_out_stall),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .o_result    (result)
    );

    assign o_out_byte   = result.out_byte;
    assign o_byte_valid = result.byte_valid;
    assign o_token_end  = result.token_end;
    assign o_line_end   = result.line_end;

endmodule

@@ design/qat_scanner.sv @@
// ----------------------------------------------------------------------------
// qat_scanner
// Holds scan mode and escape flag; classifies one byte per cycle on advance.
// ----------------------------------------------------------------------------
module qat_scanner (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  logic [7:0]         i_char,
    input  logic               i_eos,
    input  logic               i_keep_quotes,
    output qat_pkg::t_step_out o_step
);

    qat_pkg::t_mode r_mode;
    qat_pkg::t_mode n_mode;
    logic           r_esc;
    logic           n_esc;

    logic is_blank;
    logic is_quote;
    logic is_close;

    always_comb begin
        is_blank = i_char inside {qat_pkg::CH_SP, qat_pkg::CH_TAB};
        is_quote = i_char inside {qat_pkg::CH_DQ, qat_pkg::CH_SQ};
        is_close = ((r_mode == qat_pkg::MODE_DQ) && (i_char == qat_pkg::CH_DQ)) ||
                   ((r_mode == qat_pkg::MODE_SQ) && (i_char == qat_pkg::CH_SQ));
    end

    always_comb begin
        n_mode = r_mode;
        n_esc  = r_esc;
        o_step = '0;
        if (i_eos) begin
            o_step.has_result       = 1'b1;
            o_step.result.token_end = (r_mode != qat_pkg::MODE_IDLE);
            o_step.result.line_end  = 1'b1;
            n_mode = qat_pkg::MODE_IDLE;
            n_esc  = 1'b0;
        end else begin
            case (r_mode)
                qat_pkg::MODE_IDLE: begin
                    if (is_quote) begin
                        n_mode = (i_char == qat_pkg::CH_DQ) ? qat_pkg::MODE_DQ
                                                           : qat_pkg::MODE_SQ;
                        n_esc  = 1'b0;
                        if (i_keep_quotes) begin
                            o_step.has_result        = 1'b1;
                            o_step.result.out_byte   = i_char;
                            o_step.result.byte_valid = 1'b1;
                        end
                    end else if (!is_blank) begin
                        n_mode = qat_pkg::MODE_PLAIN;
                        n_esc  = (i_char == qat_pkg::CH_BS);
                        o_step.has_result        = 1'b1;
                        o_step.result.out_byte   = i_char;
                        o_step.result.byte_valid = 1'b1;
                    end
                end
                default: begin
                    // Inside a token. An escaped blank or quote is a literal byte.
                    if (r_esc && (is_blank || is_quote)) begin
                        n_esc = 1'b0;
                        o_step.has_result        = 1'b1;
                        o_step.result.out_byte   = i_char;
                        o_step.result.byte_valid = 1'b1;
                    end else if (i_char == qat_pkg::CH_BS) begin
                        n_esc = 1'b1;
                        o_step.has_result        = 1'b1;
                        o_step.result.out_byte   = i_char;
                        o_step.result.byte_valid = 1'b1;
                    end else if ((r_mode == qat_pkg::MODE_PLAIN) && is_blank) begin
                        n_esc  = 1'b0;
                        n_mode = qat_pkg::MODE_IDLE;
                        o_step.has_result       = 1'b1;
                        o_step.result.token_end = 1'b1;
                    end else if (is_close) begin
                        n_esc  = 1'b0;
                        n_mode = qat_pkg::MODE_IDLE;
                        o_step.has_result       = 1'b1;
                        o_step.result.token_end = 1'b1;
                        if (i_keep_quotes) begin
                            o_step.result.out_byte   = i_char;
                            o_step.result.byte_valid = 1'b1;
                        end
                    end else begin
                        n_esc = 1'b0;
                        o_step.has_result        = 1'b1;
                        o_step.result.out_byte   = i_char;
                        o_step.result.byte_valid = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= qat_pkg::MODE_IDLE;
            r_esc  <= 1'b0;
        end else if (i_advance) begin
            r_mode <= n_mode;
            r_esc  <= n_esc;
        end
    end

endmodule

@@ design/qat_result_reg.sv @@
// ----------------------------------------------------------------------------
// qat_result_reg
// Output register that holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module qat_result_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  qat_pkg::t_step_out i_step,
    input  logic               i_out_stall,
    output logic               o_free,
    output logic               o_out_valid,
    output qat_pkg::t_result   o_result
);

    logic             r_valid;
    qat_pkg::t_result r_result;

    // The register can take a new result when it is empty or is being drained.
    assign o_free      = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;
    assign o_result    = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_advance && i_step.has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_advance && i_step.has_result) begin
            r_result <= i_step.result;
        end
    end

endmodule

@@ bench/tb_quoted_argument_tokenizer.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quoted_argument_tokenizer
// Self-checking bench for the streaming argument tokenizer.
// ----------------------------------------------------------------------------
// A short hand-written byte string exercises blanks, quotes, escapes, empty
// and unterminated tokens and the terminator. Random command lines follow:
// plain, double- and single-quoted tokens with random content, escapes and
// separators, mixed with raw noise bytes. keep_quotes is rewritten between
// phases while the pipe is empty. A scoreboard tracks the tokenizer state
// on every accepted input byte and checks each result in order. The sender
// pauses in bursts, and the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module tb_quoted_argument_tokenizer;

    localparam int unsigned PHASES          = 8;
    localparam int unsigned ITEMS_PER_PHASE = 215;
    localparam int unsigned WATCHDOG_LIMIT  = 5000;
    localparam int unsigned DRAIN_CYCLES    = 6;

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the tokenizer state and holds the results that are
    // still owed by the block, oldest first.
    // ------------------------------------------------------------------------
    class token_scoreboard;
        qat_pkg::t_mode   mode;
        bit               escape_armed;
        bit               keep_quotes;
        qat_pkg::t_result owed_results[$];
        int unsigned      fails;

        function new();
            mode         = qat_pkg::MODE_IDLE;
            escape_armed = 1'b0;
            keep_quotes  = 1'b0;
            fails        = 0;
        endfunction

        function void set_keep(bit k);
            keep_quotes = k;
        endfunction

        function int unsigned pending();
            return owed_results.size();
        endfunction

        function void owe(logic [7:0] b, bit bv, bit te, bit le);
            qat_pkg::t_result r;
            r.out_byte   = bv ? b : 8'h00;
            r.byte_valid = bv;
            r.token_end  = te;
            r.line_end   = le;
            owed_results.push_back(r);
        endfunction

        // Advance the tokenizer by one accepted byte and record what it owes.
        function void note_input(logic [7:0] c, logic eos);
            bit blank;
            bit quote;
            blank = (c == qat_pkg::CH_SP) || (c == qat_pkg::CH_TAB);
            quote = (c == qat_pkg::CH_DQ) || (c == qat_pkg::CH_SQ);
            if (eos) begin
                owe(8'h00, 1'b0, mode != qat_pkg::MODE_IDLE, 1'b1);
                mode         = qat_pkg::MODE_IDLE;
                escape_armed = 1'b0;
                return;
            end
            if (mode == qat_pkg::MODE_IDLE) begin
                if (blank) return;
                if (quote) begin
                    mode         = (c == qat_pkg::CH_DQ) ? qat_pkg::MODE_DQ
                                                         : qat_pkg::MODE_SQ;
                    escape_armed = 1'b0;
                    if (keep_quotes) owe(c, 1'b1, 1'b0, 1'b0);
                    return;
                end
                mode         = qat_pkg::MODE_PLAIN;
                escape_armed = (c == qat_pkg::CH_BS);
                owe(c, 1'b1, 1'b0, 1'b0);
                return;
            end
            // Inside a token: an escaped blank or quote is just a byte.
            if (escape_armed) begin
                escape_armed = 1'b0;
                if (blank || quote) begin
                    owe(c, 1'b1, 1'b0, 1'b0);
                    return;
                end
            end
            if (c == qat_pkg::CH_BS) begin
                escape_armed = 1'b1;
                owe(c, 1'b1, 1'b0, 1'b0);
                return;
            end
            if (mode == qat_pkg::MODE_PLAIN && blank) begin
                mode = qat_pkg::MODE_IDLE;
                owe(8'h00, 1'b0, 1'b1, 1'b0);
                return;
            end
            if ((mode == qat_pkg::MODE_DQ && c == qat_pkg::CH_DQ) ||
                (mode == qat_pkg::MODE_SQ && c == qat_pkg::CH_SQ)) begin
                mode = qat_pkg::MODE_IDLE;
                owe(c, keep_quotes, 1'b1, 1'b0);
                return;
            end
            owe(c, 1'b1, 1'b0, 1'b0);
        endfunction

        function void check_result(qat_pkg::t_result got);
            qat_pkg::t_result want;
            if (owed_results.size() == 0) begin
                $error({"result with nothing owed: out_byte %02h byte_valid %0b",
                        " token_end %0b line_end %0b"},
                       got.out_byte, got.byte_valid, got.token_end, got.line_end);
                fails++;
                return;
            end
            want = owed_results.pop_front();
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte: expected %02h, actual %02h", want.out_byte, got.out_byte);
                fails++;
            end
            if (got.byte_valid !== want.byte_valid) begin
                $error("byte_valid: expected %0b, actual %0b", want.byte_valid, got.byte_valid);
                fails++;
            end
            if (got.token_end !== want.token_end) begin
                $error("token_end: expected %0b, actual %0b", want.token_end, got.token_end);
                fails++;
            end
            if (got.line_end !== want.line_end) begin
                $error("line_end: expected %0b, actual %0b", want.line_end, got.line_end);
                fails++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals around the block.
    // ------------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_char_in;
    logic        i_end_of_string;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_out_byte;
    logic        o_byte_valid;
    logic        o_token_end;
    logic        o_line_end;

    token_scoreboard sb;

    // Sender pacing: a burst of transfers, then a random gap, repeated.
    bit          sender_pauses;
    int unsigned burst_left;
    int unsigned items_sent;

    // Receiver stall pattern.
    int unsigned stall_style;
    int unsigned stall_run;
    int unsigned stall_tick;

    // Monitor and watchdog bookkeeping.
    bit          in_xfer;
    bit          out_xfer;
    int unsigned quiet_cycles;

    quoted_argument_tokenizer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_char_in       (i_char_in),
        .i_end_of_string (i_end_of_string),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_byte      (o_out_byte),
        .o_byte_valid    (o_byte_valid),
        .o_token_end     (o_token_end),
        .o_line_end      (o_line_end)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Monitors and watchdog. Both channels are sampled at the rising edge;
    // every input the bench drives changes only at the falling edge, so the
    // values seen here are settled. The watchdog ends the run when neither
    // channel nor the register port has moved for too long.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            in_xfer  = i_in_valid && !o_in_stall;
            out_xfer = o_out_valid && !i_out_stall;
            if (in_xfer) sb.note_input(i_char_in, i_end_of_string);
            if (out_xfer) begin
                sb.check_result('{out_byte:   o_out_byte,
                                  byte_valid: o_byte_valid,
                                  token_end:  o_token_end,
                                  line_end:   o_line_end});
            end
            if (in_xfer || out_xfer || psel) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("quoted_argument_tokenizer verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: switches between never stalling, light and heavy random
    // stalls, and a fixed periodic pattern, each held for a random stretch.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (stall_run == 0) begin
            stall_style = $urandom_range(0, 3);
            stall_run   = $urandom_range(40, 300);
        end
        stall_run--;
        stall_tick++;
        case (stall_style)
            0: begin
                i_out_stall <= 1'b0;
            end
            1: begin
                i_out_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
                i_out_stall <= ($urandom_range(0, 9) < 7);
            end
            default: begin
                i_out_stall <= ((stall_tick % 7) < 3);
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Drive one byte and hold it until the block takes it. A gap, when one
    // falls due, drops valid for a few cycles first.
    // ------------------------------------------------------------------------
    task automatic send(input logic [7:0] c, input logic eos);
        int unsigned gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = sender_pauses ? $urandom_range(1, 12) : 0;
        end
        burst_left--;
        if (gap != 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid      <= 1'b1;
        i_char_in       <= c;
        i_end_of_string <= eos;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
    endtask

    // Drop valid and wait until every owed result has come back, then give
    // bytes that cause no result time to leave the two-stage pipe.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_reg(input int unsigned idx, input logic [31:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(idx * 4);
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == qat_pkg::REG_KEEP_QUOTES) sb.set_keep(value[0]);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Random byte biased toward the characters the tokenizer reacts to.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 15))
            0:       return qat_pkg::CH_SP;
            1:       return qat_pkg::CH_TAB;
            2:       return qat_pkg::CH_DQ;
            3:       return qat_pkg::CH_SQ;
            4:       return qat_pkg::CH_BS;
            5:       return 8'h00;
            6:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Random blank, space or tab.
    function automatic logic [7:0] pick_blank();
        return $urandom_range(0, 1) ? qat_pkg::CH_SP : qat_pkg::CH_TAB;
    endfunction

    // ------------------------------------------------------------------------
    // One command line: a few tokens of mixed kinds with random content,
    // separated by blanks, closed by the terminator most of the time.
    // ------------------------------------------------------------------------
    task automatic send_line();
        int unsigned n_tokens;
        int unsigned kind;
        int unsigned len;
        logic [7:0]  c;
        logic [7:0]  q;
        n_tokens = $urandom_range(0, 5);
        repeat ($urandom_range(0, 2)) send(pick_blank(), 1'b0);
        for (int t = 0; t < n_tokens; t++) begin
            kind = $urandom_range(0, 2);
            len  = $urandom_range(0, 7);
            if (kind == 0) begin
                // Plain token; blanks inside are escaped so the token holds.
                c = ($urandom_range(0, 3) == 0) ? qat_pkg::CH_BS
                                                : 8'($urandom_range(33, 126));
                send(c, 1'b0);
                for (int i = 0; i < len; i++) begin
                    c = pick_byte();
                    if (c == qat_pkg::CH_SP || c == qat_pkg::CH_TAB) begin
                        send(qat_pkg::CH_BS, 1'b0);
                    end
                    send(c, 1'b0);
                end
                send(pick_blank(), 1'b0);
            end else begin
                // Quoted token; the matching quote inside is escaped.
                q = (kind == 1) ? qat_pkg::CH_DQ : qat_pkg::CH_SQ;
                send(q, 1'b0);
                for (int i = 0; i < len; i++) begin
                    c = pick_byte();
                    if (c == q) send(qat_pkg::CH_BS, 1'b0);
                    send(c, 1'b0);
                end
                if ($urandom_range(0, 9) != 0) send(q, 1'b0);
                repeat ($urandom_range(0, 2)) send(qat_pkg::CH_SP, 1'b0);
            end
        end
        if ($urandom_range(0, 9) != 0) send(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Unstructured bytes, with the terminator now and then.
    task automatic send_noise();
        repeat ($urandom_range(1, 12)) begin
            send($urandom_range(0, 1) ? pick_byte() : 8'($urandom_range(0, 255)),
                 ($urandom_range(0, 7) == 0));
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        logic [8:0] directed [];
        sb = new();

        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        i_in_valid      = 1'b0;
        i_char_in       = 8'h00;
        i_end_of_string = 1'b0;
        i_out_stall     = 1'b0;
        sender_pauses   = 1'b1;
        burst_left      = 0;
        items_sent      = 0;
        stall_style     = 0;
        stall_run       = 0;
        stall_tick      = 0;
        quiet_cycles    = 0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed string with quotes stripped. Bit 8 marks the terminator.
        // It covers: a terminator with no token open, the zero and all-ones
        // bytes inside a plain token, blanks between tokens, a single quote
        // literal inside a double-quoted token, a token opened right after a
        // closing quote, an empty quoted token, an escaped blank and a bare quote in a
        // plain token, a backslash before an ordinary byte, an escaped quote
        // inside quotes, and an unterminated quote closed by the terminator.
        write_reg(qat_pkg::REG_KEEP_QUOTES, 32'h0000_0000);
        directed = '{
            {1'b1, 8'hA5},
            {1'b0, 8'h00}, {1'b0, 8'hFF}, {1'b0, qat_pkg::CH_TAB},
            {1'b0, qat_pkg::CH_SP}, {1'b0, qat_pkg::CH_TAB},
            {1'b0, qat_pkg::CH_DQ}, {1'b0, 8'h61}, {1'b0, qat_pkg::CH_SP},
            {1'b0, qat_pkg::CH_SQ}, {1'b0, qat_pkg::CH_DQ},
            {1'b0, qat_pkg::CH_SQ}, {1'b0, qat_pkg::CH_SQ},
            {1'b0, qat_pkg::CH_BS}, {1'b0, qat_pkg::CH_SP}, {1'b0, qat_pkg::CH_DQ},
            {1'b0, qat_pkg::CH_BS}, {1'b0, 8'h78},
            {1'b0, qat_pkg::CH_SP},
            {1'b0, qat_pkg::CH_DQ}, {1'b0, qat_pkg::CH_BS}, {1'b0, qat_pkg::CH_DQ},
            {1'b0, 8'h7A},
            {1'b1, 8'h00}
        };
        foreach (directed[i]) send(directed[i][7:0], directed[i][8]);
        settle();

        // Random phases, alternating keep_quotes. Upper data bits are noise
        // that the register must ignore. One phase also writes an address
        // past the last register, which must change nothing.
        for (int p = 0; p < PHASES; p++) begin
            write_reg(qat_pkg::REG_KEEP_QUOTES,
                      {$urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'h0,
                       (p % 2 == 0) ? 1'b1 : 1'b0});
            if (p == 3) write_reg(qat_pkg::REG_KEEP_QUOTES + 1, 32'h0000_0001);
            sender_pauses = ($urandom_range(0, 3) != 0);
            while (items_sent < 25 + (p + 1) * ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 9) < 8) begin
                    send_line();
                end else begin
                    send_noise();
                end
            end
            settle();
        end

        if (sb.fails == 0 && sb.pending() == 0) begin
            $display("quoted_argument_tokenizer verification clean");
        end else begin
            $display("quoted_argument_tokenizer verification failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/qat_pkg.sv
design/qat_scanner.sv
design/qat_result_reg.sv
design/quoted_argument_tokenizer.sv
bench/tb_quoted_argument_tokenizer.sv
